@@ sv/bpa_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bpa_pkg
// Shared constants and codes of the bitmap page allocator.
// ----------------------------------------------------------------------------
package bpa_pkg;
  localparam int NUM_RANGES_DEF      = 4;
  localparam int PAGES_PER_RANGE_DEF = 4096;
  localparam int PAGE_BYTES_DEF      = 4096;
  localparam int PAGE_W  = 36;
  localparam int COUNT_W = 13;
  localparam int HDR_FIXED_BYTES = 16;
  localparam int BITS_PER_BYTE   = 8;

  typedef enum logic [1:0] {
    REQ_ALLOC = 2'd0,
    REQ_FREE  = 2'd1,
    REQ_ADD   = 2'd2,
    REQ_BAD   = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOFREE   = 2'd1,
    ST_OUTRANGE = 2'd2,
    ST_REJECT   = 2'd3
  } status_t;
endpackage
`default_nettype wire

@@ sv/bpa_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bpa_ram
// Single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module bpa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

@@ sv/bitmap_page_allocator_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bitmap_page_allocator_top
// First-fit page allocator over a used-bit map held in one RAM.
// ----------------------------------------------------------------------------
// channel  | handshake      | payload
// request  | start && !busy | req_type, page_number, page_count
// result   | done (1 cycle) | status, result_page
//
// Allocate reads each map word, then tests it and writes it back, newest range
// first, stopping at the first free page it finds.
// Add writes the range's WPR words one per cycle, header bits included (64).
// Free compares one range per cycle, then reads and writes one word.
// Rejects answer at once; done is registered, rising in the cycle after the last step.
// Reset is synchronous, returns to idle and clears the range table; the map
// is written before it is read. The result cannot be stalled; busy stays high until done.
// ----------------------------------------------------------------------------
module bitmap_page_allocator_top #(
  parameter int NUM_RANGES      = bpa_pkg::NUM_RANGES_DEF,
  parameter int PAGES_PER_RANGE = bpa_pkg::PAGES_PER_RANGE_DEF,
  parameter int PAGE_BYTES      = bpa_pkg::PAGE_BYTES_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic [1:0]                 req_type,
  input  wire logic [bpa_pkg::PAGE_W-1:0] page_number,
  input  wire logic [bpa_pkg::COUNT_W-1:0] page_count,
  output logic                            done,
  output logic [1:0]                      status,
  output logic [bpa_pkg::PAGE_W-1:0]      result_page
);
  localparam int WPR    = (PAGES_PER_RANGE + 63) / 64;
  localparam int WPR_W  = (WPR > 1) ? $clog2(WPR) : 1;
  localparam int SLOT_W = (NUM_RANGES > 1) ? $clog2(NUM_RANGES) : 1;
  localparam int DEPTH  = NUM_RANGES * WPR;
  localparam int ADDR_W = $clog2(DEPTH) > 0 ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(NUM_RANGES + 1);
  localparam int PW     = bpa_pkg::PAGE_W;
  localparam int CW     = bpa_pkg::COUNT_W;
  localparam int HW     = 24;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_AREAD = 7'b0000010,
    S_ATEST = 7'b0000100,
    S_FSCAN = 7'b0001000,
    S_FREAD = 7'b0010000,
    S_FWRT  = 7'b0100000,
    S_CLR   = 7'b1000000
  } state_t;

  state_t state;
  logic [PW-1:0] base_r [NUM_RANGES];
  logic [CW-1:0] size_r [NUM_RANGES];
  logic [CNT_W-1:0] in_use;
  logic [SLOT_W-1:0] slot;
  logic [CNT_W-1:0] k;
  logic [WPR_W-1:0] word;
  logic [CW-1:0] off;
  logic [CW-1:0] hdr;
  logic [PW-1:0] pg;
  logic [CW-1:0] cnt;

  logic we;
  logic [ADDR_W-1:0] addr;
  logic [63:0] wdata, rdata;

  bpa_ram #(.WIDTH(64), .DEPTH(DEPTH)) u_map (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
  );

  // header pages of the requested range, counted up to three; at the default page size a 13-bit count needs only one
  logic [HW-1:0] hbytes;
  logic [1:0]    hp;
  assign hbytes = ((HW'(page_count) + HW'(bpa_pkg::BITS_PER_BYTE - 1)) >> 3)
                  + HW'(bpa_pkg::HDR_FIXED_BYTES);
  assign hp = 2'd1 + 2'(hbytes > HW'(PAGE_BYTES)) + 2'(hbytes > HW'(2 * PAGE_BYTES));

  logic [SLOT_W-1:0] ks;
  assign ks = SLOT_W'(k - CNT_W'(1));

  logic [PW-1:0] fdiff;
  assign fdiff = pg - base_r[ks];

  // range-local page index of the word's bit 0, and first zero bit among valid pages
  logic [CW+6:0] pbase;
  assign pbase = (CW+7)'(word) << 6;
  logic        zfound;
  logic [5:0]  zidx;
  always_comb begin
    zfound = 1'b0;
    zidx   = '0;
    for (int b = 63; b >= 0; b--) begin
      if (!rdata[b] && ((pbase + (CW+7)'(b)) < (CW+7)'(size_r[slot]))) begin
        zfound = 1'b1;
        zidx   = 6'(b);
      end
    end
  end

  logic [63:0] hmask;
  always_comb begin
    for (int b = 0; b < 64; b++) begin
      hmask[b] = (pbase + (CW+7)'(b)) < (CW+7)'(hdr);
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    we    = 1'b0;
    wdata = rdata;
    addr  = ADDR_W'(slot * WPR + int'(word));
    unique case (state)
      S_ATEST: begin
        if (zfound) begin
          we    = 1'b1;
          wdata = rdata | (64'd1 << zidx);
        end
      end
      S_FWRT: begin
        we    = 1'b1;
        wdata = rdata & ~(64'd1 << off[5:0]);
      end
      S_CLR: begin
        we    = 1'b1;
        wdata = hmask;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      state  <= S_IDLE;
      in_use <= '0;
      for (int i = 0; i < NUM_RANGES; i++) begin
        base_r[i] <= '0;
        size_r[i] <= '0;
      end
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            pg  <= page_number;
            cnt <= page_count;
            result_page <= '0;
            unique case (req_type)
              bpa_pkg::REQ_ALLOC: begin
                if (in_use == '0) begin
                  done   <= 1'b1;
                  status <= bpa_pkg::ST_NOFREE;
                end else begin
                  slot  <= SLOT_W'(in_use - CNT_W'(1));
                  word  <= '0;
                  state <= S_AREAD;
                end
              end
              bpa_pkg::REQ_FREE: begin
                k     <= in_use;
                state <= S_FSCAN;
              end
              bpa_pkg::REQ_ADD: begin
                if (in_use < CNT_W'(NUM_RANGES) && 32'(page_count) <= PAGES_PER_RANGE
                    && page_count >= CW'(hp)) begin
                  slot  <= SLOT_W'(in_use);
                  word  <= '0;
                  hdr   <= CW'(hp);
                  state <= S_CLR;
                end else begin
                  done   <= 1'b1;
                  status <= bpa_pkg::ST_REJECT;
                end
              end
              default: begin
                done   <= 1'b1;
                status <= bpa_pkg::ST_REJECT;
              end
            endcase
          end
        end
        S_AREAD: state <= S_ATEST;
        S_ATEST: begin
          if (zfound) begin
            done        <= 1'b1;
            status      <= bpa_pkg::ST_OK;
            result_page <= base_r[slot] + PW'(pbase + (CW+7)'(zidx));
            state       <= S_IDLE;
          end else if (int'(word) != WPR - 1 && (pbase + 64) < (CW+7)'(size_r[slot])) begin
            word  <= word + WPR_W'(1);
            state <= S_AREAD;
          end else if (slot != '0) begin
            slot  <= slot - SLOT_W'(1);
            word  <= '0;
            state <= S_AREAD;
          end else begin
            done   <= 1'b1;
            status <= bpa_pkg::ST_NOFREE;
            state  <= S_IDLE;
          end
        end
        S_FSCAN: begin
          if (k == '0) begin
            done   <= 1'b1;
            status <= bpa_pkg::ST_OUTRANGE;
            state  <= S_IDLE;
          end else if (fdiff < PW'(size_r[ks])) begin
            slot  <= ks;
            off   <= CW'(fdiff);
            word  <= WPR_W'(fdiff[CW-1:6]);
            state <= S_FREAD;
          end else begin
            k <= k - CNT_W'(1);
          end
        end
        S_FREAD: state <= S_FWRT;
        S_FWRT: begin
          done   <= 1'b1;
          status <= bpa_pkg::ST_OK;
          state  <= S_IDLE;
        end
        S_CLR: begin
          if (int'(word) == WPR - 1) begin
            base_r[slot] <= pg;
            size_r[slot] <= cnt;
            in_use       <= in_use + CNT_W'(1);
            done         <= 1'b1;
            status       <= bpa_pkg::ST_OK;
            state        <= S_IDLE;
          end else begin
            word <= word + WPR_W'(1);
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

@@ sv/bpa_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bpa_checker
// Port-level checks of the page allocator, bound to the top level.
// ----------------------------------------------------------------------------
module bpa_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        start,
  input wire logic        busy,
  input wire logic [1:0]  req_type,
  input wire logic        done,
  input wire logic [1:0]  status,
  input wire logic [35:0] result_page
);
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("done while busy");
  a_done_from_work: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy) || $past(start)) else $error("done without request");
  a_page_zero: assert property (@(posedge clk) disable iff (rst)
    done && status != bpa_pkg::ST_OK |-> result_page == '0) else $error("page not zero");
  a_bad_req: assert property (@(posedge clk) disable iff (rst)
    start && !busy && req_type == bpa_pkg::REQ_BAD |=> done && status == bpa_pkg::ST_REJECT)
    else $error("bad request not rejected");
endmodule

bind bitmap_page_allocator_top bpa_checker u_chk (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .req_type(req_type),
  .done(done), .status(status), .result_page(result_page)
);
`default_nettype wire
